// ===== rtl/core/ssmm_pkg.sv =====
`timescale 1ns / 1ps
package ssmm_pkg;

  localparam int RAM_ADDRESS_BITS = 22;
  localparam int DEV_ADDR_W       = 22;
  localparam int CFG_ADDR_W       = 3;
  localparam int CFG_DATA_W       = 32;

  localparam logic [DEV_ADDR_W-1:0] RAM_MASK =
    DEV_ADDR_W'((64'd1 << RAM_ADDRESS_BITS) - 64'd1);

  localparam logic [15:0] ADDR_SEC_SLOT = 16'hFFFF;
  localparam int          PAGE_SHIFT    = 14;

  localparam logic [7:0] PORT_VDP      = 8'h98;
  localparam logic [7:0] PORT_PSG_SEL  = 8'hA0;
  localparam logic [7:0] PORT_PSG_DATA = 8'hA1;
  localparam logic [7:0] PORT_PSG_READ = 8'hA2;
  localparam logic [7:0] PORT_PPI_A    = 8'hA8;
  localparam logic [7:0] PORT_PPI_B    = 8'hA9;
  localparam logic [7:0] PORT_PPI_C    = 8'hAA;
  localparam logic [7:0] PORT_MAPPER   = 8'hFC;
  localparam logic [7:0] BYTE_FF       = 8'hFF;

  localparam logic [CFG_ADDR_W-1:0] CFG_PLAIN_MODEL = 3'h0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SUB_ROM     = 3'h4;

  typedef enum logic [1:0] {
    ACT_MEM_READ   = 2'd0,
    ACT_MEM_WRITE  = 2'd1,
    ACT_PORT_READ  = 2'd2,
    ACT_PORT_WRITE = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    TGT_INTERNAL  = 4'd0,
    TGT_BIOS      = 4'd1,
    TGT_CART      = 4'd2,
    TGT_EXPANSION = 4'd3,
    TGT_RAM       = 4'd4,
    TGT_SUBROM    = 4'd5,
    TGT_VIDEO     = 4'd6,
    TGT_SOUND     = 4'd7,
    TGT_KEYBOARD  = 4'd8,
    TGT_DROPPED   = 4'd9
  } target_t;

  localparam logic [1:0] SLOT_BIOS = 2'd0;
  localparam logic [1:0] SLOT_CART = 2'd1;
  localparam logic [1:0] SLOT_EXP  = 2'd2;
  localparam logic [1:0] SUB_RAM   = 2'd0;
  localparam logic [1:0] SUB_ROM   = 2'd1;
  localparam logic [1:0] REG_PSG_SEL  = 2'd0;
  localparam logic [1:0] REG_PSG_DATA = 2'd1;

  typedef logic [3:0][1:0] slot_row_t;
  typedef logic [3:0][7:0] bank_set_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] address;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic [3:0]            target;
    logic [DEV_ADDR_W-1:0] device_address;
    logic [1:0]            device_register;
    logic [7:0]            write_value;
    logic [7:0]            read_value;
  } result_t;

  typedef struct packed {
    logic       pri_we;
    logic       sec_we;
    logic [1:0] sec_row;
    logic       map_we;
    logic [1:0] map_idx;
    logic [7:0] data;
  } update_t;

  typedef struct packed {
    logic plain_model;
    logic sub_rom_present;
  } cfg_t;

endpackage

// ===== rtl/core/ssmm_if.sv =====
`timescale 1ns / 1ps
interface ssmm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] address;
  logic [7:0]  data;

  modport source (output valid, action, address, data, input ready);
  modport sink (input valid, action, address, data, output ready);
endinterface

interface ssmm_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  target;
  logic [21:0] device_address;
  logic [1:0]  device_register;
  logic [7:0]  write_value;
  logic [7:0]  read_value;

  modport source (output valid, target, device_address, device_register, write_value,
                  read_value, input ready);
  modport sink (input valid, target, device_address, device_register, write_value,
                read_value, output ready);
endinterface

// ===== rtl/core/slot_select_memory_mapper.sv =====
`timescale 1ns / 1ps
// Slot select and memory mapper. Decodes one CPU bus transaction per cycle
// into a target device and device address while out_bus.ready does not stall.
// A transaction is captured in an input register and decoded against the slot
// and mapper registers on its way into the result register, so transactions
// stream at one per cycle unless the output is stalled. Slot register, secondary slot
// (FFFF) and mapper port writes take effect for the very next transaction.
// The APB port holds plain_model at 0x0 and sub_rom_present at 0x4.
module slot_select_memory_mapper (
  input  logic                                 clk,
  input  logic                                 rst_n,
  ssmm_in_if.sink                              in_bus,
  ssmm_out_if.source                           out_bus,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ssmm_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [ssmm_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [ssmm_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready
);
  import ssmm_pkg::*;

  logic                s1_valid_r;
  item_t               s1_item_r;
  logic                out_valid_r;
  result_t             out_res_r;
  cfg_t                cfg_r;
  slot_row_t           pri_r;
  slot_row_t [3:0]     sec_r;
  bank_set_t           bank_r;
  result_t             dec_res;
  update_t             dec_upd;
  logic                s1_adv;
  logic                cfg_wr;

  assign s1_adv       = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !s1_valid_r || s1_adv;
  assign cfg_wr       = psel && penable && pwrite;
  assign pready       = 1'b1;

  always_comb begin
    prdata = '0;
    case (paddr[2])
      CFG_PLAIN_MODEL[2]: prdata[0] = cfg_r.plain_model;
      default:            prdata[0] = cfg_r.sub_rom_present;
    endcase
  end

  ssmm_decode u_decode (
    .item      (s1_item_r),
    .cfg       (cfg_r),
    .primary   (pri_r),
    .secondary (sec_r),
    .bank      (bank_r),
    .res       (dec_res),
    .upd       (dec_upd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == CFG_SUB_ROM[2]) begin
        cfg_r.sub_rom_present <= pwdata[0];
      end else begin
        cfg_r.plain_model <= pwdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      s1_item_r <= '{action: in_bus.action, address: in_bus.address, data: in_bus.data};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= dec_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pri_r  <= '0;
      sec_r  <= '0;
      bank_r <= '0;
    end else if (s1_adv) begin
      if (dec_upd.pri_we) begin
        pri_r <= dec_upd.data;
      end
      if (dec_upd.sec_we) begin
        sec_r[dec_upd.sec_row] <= dec_upd.data;
      end
      if (dec_upd.map_we) begin
        bank_r[dec_upd.map_idx] <= dec_upd.data;
      end
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.target          = out_res_r.target;
  assign out_bus.device_address  = out_res_r.device_address;
  assign out_bus.device_register = out_res_r.device_register;
  assign out_bus.write_value     = out_res_r.write_value;
  assign out_bus.read_value      = out_res_r.read_value;

endmodule

// ===== rtl/core/ssmm_decode.sv =====
`timescale 1ns / 1ps
module ssmm_decode (
  input  ssmm_pkg::item_t              item,
  input  ssmm_pkg::cfg_t               cfg,
  input  ssmm_pkg::slot_row_t          primary,
  input  ssmm_pkg::slot_row_t [3:0]    secondary,
  input  ssmm_pkg::bank_set_t          bank,
  output ssmm_pkg::result_t            res,
  output ssmm_pkg::update_t            upd
);
  import ssmm_pkg::*;

  logic [1:0]            page;
  logic [1:0]            prim;
  logic [1:0]            sec;
  logic [7:0]            port;
  logic [7:0]            pack_pri;
  logic [7:0]            pack_sec;
  logic [DEV_ADDR_W-1:0] ram_addr;
  logic [DEV_ADDR_W-1:0] port_addr;

  assign page      = item.address[15:PAGE_SHIFT];
  assign prim      = primary[page];
  assign sec       = secondary[prim][page];
  assign port      = item.address[7:0];
  assign pack_pri  = primary;
  assign pack_sec  = secondary[primary[3]];
  assign port_addr = DEV_ADDR_W'(port);

  always_comb begin
    if (cfg.plain_model) begin
      ram_addr = DEV_ADDR_W'(item.address);
    end else begin
      ram_addr = DEV_ADDR_W'({bank[page], item.address[PAGE_SHIFT-1:0]}) & RAM_MASK;
    end
  end

  always_comb begin
    res.target          = TGT_INTERNAL;
    res.device_address  = DEV_ADDR_W'(item.address);
    res.device_register = 2'd0;
    res.write_value     = 8'd0;
    res.read_value      = 8'd0;
    upd.pri_we          = 1'b0;
    upd.sec_we          = 1'b0;
    upd.sec_row         = primary[3];
    upd.map_we          = 1'b0;
    upd.map_idx         = port[1:0];
    upd.data            = item.data;
    case (action_t'(item.action))
      ACT_MEM_READ: begin
        if (item.address == ADDR_SEC_SLOT) begin
          res.read_value = ~pack_sec;
        end else begin
          case (prim)
            SLOT_BIOS: res.target = TGT_BIOS;
            SLOT_CART: res.target = TGT_CART;
            SLOT_EXP:  res.target = TGT_EXPANSION;
            default: begin
              if (sec == SUB_RAM) begin
                res.target         = TGT_RAM;
                res.device_address = ram_addr;
              end else if (sec == SUB_ROM && cfg.sub_rom_present) begin
                res.target = TGT_SUBROM;
              end else begin
                res.read_value = BYTE_FF;
              end
            end
          endcase
        end
      end
      ACT_MEM_WRITE: begin
        res.write_value = item.data;
        if (item.address == ADDR_SEC_SLOT) begin
          upd.sec_we = 1'b1;
        end else begin
          case (prim)
            SLOT_BIOS: res.target = TGT_DROPPED;
            SLOT_CART: res.target = TGT_CART;
            SLOT_EXP:  res.target = TGT_EXPANSION;
            default: begin
              res.target         = TGT_RAM;
              res.device_address = ram_addr;
            end
          endcase
        end
      end
      ACT_PORT_READ: begin
        res.device_address = port_addr;
        if (port[7:2] == PORT_VDP[7:2]) begin
          res.target          = TGT_VIDEO;
          res.device_register = port[1:0];
        end else if (port == PORT_PSG_READ) begin
          res.target          = TGT_SOUND;
          res.device_register = REG_PSG_DATA;
        end else if (port == PORT_PPI_A) begin
          res.read_value = pack_pri;
        end else if (port == PORT_PPI_B) begin
          res.target = TGT_KEYBOARD;
        end else if (port[7:2] == PORT_MAPPER[7:2]) begin
          res.read_value = cfg.plain_model ? BYTE_FF : bank[port[1:0]];
        end else begin
          res.read_value = BYTE_FF;
        end
      end
      default: begin
        res.device_address = port_addr;
        res.write_value    = item.data;
        if (port[7:2] == PORT_VDP[7:2]) begin
          res.target          = TGT_VIDEO;
          res.device_register = port[1:0];
        end else if (port == PORT_PSG_SEL) begin
          res.target          = TGT_SOUND;
          res.device_register = REG_PSG_SEL;
        end else if (port == PORT_PSG_DATA) begin
          res.target          = TGT_SOUND;
          res.device_register = REG_PSG_DATA;
        end else if (port == PORT_PPI_A) begin
          upd.pri_we = 1'b1;
        end else if (port == PORT_PPI_C) begin
          res.target      = TGT_KEYBOARD;
          res.write_value = {4'd0, item.data[3:0]};
        end else if (port[7:2] == PORT_MAPPER[7:2]) begin
          upd.map_we = 1'b1;
        end else begin
          res.target = TGT_DROPPED;
        end
      end
    endcase
  end

endmodule

// ===== rtl/core/ssmm_checker.sv =====
`timescale 1ns / 1ps
module ssmm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_target,
  input logic [21:0] out_device_address,
  input logic [1:0]  out_device_register,
  input logic [7:0]  out_write_value,
  input logic [7:0]  out_read_value
);
  import ssmm_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_target) &&
      $stable(out_device_address) && $stable(out_write_value) && $stable(out_read_value))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_kbd_nibble: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_target == TGT_KEYBOARD |-> out_write_value[7:4] == 4'd0)
    else $error("keyboard write value wider than a nibble");

  a_rdata_internal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_target != TGT_INTERNAL |-> out_read_value == 8'd0)
    else $error("read value on a device transaction");

  a_reg_device: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_target != TGT_VIDEO && out_target != TGT_SOUND
      |-> out_device_register == 2'd0)
    else $error("device register on a non-register target");

endmodule

bind slot_select_memory_mapper ssmm_checker u_ssmm_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_bus.valid),
  .out_ready           (out_bus.ready),
  .out_target          (out_bus.target),
  .out_device_address  (out_bus.device_address),
  .out_device_register (out_bus.device_register),
  .out_write_value     (out_bus.write_value),
  .out_read_value      (out_bus.read_value)
);
